// ===== design/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; include once per compilation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define CDC_ASSERT_NOW(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication; the property carries its own |=> operator.
`define CDC_ASSERT_NEXT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== design/cdc_pkg.sv =====
// Shared types, codes and constants of the calendar date counter.
// Depends on nothing; imported by every module of the block.
package cdc_pkg;

    localparam int YEAR_BITS = 16;
    // Compare width: holds the signed input year and the stored year.
    localparam int CMP_W = ((YEAR_BITS > 17) ? YEAR_BITS : 17) + 1;

    localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;
    localparam logic signed [CMP_W-1:0] CMP_YEAR_MAX = CMP_W'(YEAR_MAX);

    // Inverse of an odd number modulo 2**YEAR_BITS by Newton steps.
    function automatic logic [YEAR_BITS-1:0] inv_odd(input logic [YEAR_BITS-1:0] a);
        logic [YEAR_BITS-1:0] x;
        x = a;
        for (int i = 0; i < 6; i++) begin
            x = x * (YEAR_BITS'(2) - a * x);
        end
        return x;
    endfunction

    // y is a multiple of 25 exactly when y * inv(25) wraps to at most YEAR_MAX / 25.
    localparam logic [YEAR_BITS-1:0] INV25     = inv_odd(YEAR_BITS'(25));
    localparam logic [YEAR_BITS-1:0] DIV25_LIM = YEAR_MAX / 25;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] DAY_FIRST = 5'd1;
    localparam logic [4:0] DAYS_31   = 5'd31;
    localparam logic [4:0] DAYS_30   = 5'd30;
    localparam logic [4:0] DAYS_29   = 5'd29;
    localparam logic [4:0] DAYS_28   = 5'd28;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_ADD  = 2'd1;
    localparam logic [1:0] CMD_SUB  = 2'd2;
    localparam logic [1:0] CMD_CMP  = 2'd3;

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_BAD_MONTH = 3'd1;
    localparam logic [2:0] STAT_BAD_YEAR  = 3'd2;
    localparam logic [2:0] STAT_BAD_DAY   = 3'd3;
    localparam logic [2:0] STAT_LIMIT     = 3'd4;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_LOAD = 5'b00010,
        ST_FWD  = 5'b00100,
        ST_BACK = 5'b01000,
        ST_CMP  = 5'b10000
    } t_state;

    // Operands of the shared month-length unit.
    typedef struct packed {
        logic [YEAR_BITS-1:0] year;
        logic [3:0]           month;
    } t_mlen_req;

endpackage

// ===== design/cdc_mlen.sv =====
// Shared month-length unit: leap-year test and days in a month.
// Depends on cdc_pkg.
module cdc_mlen (
    input  cdc_pkg::t_mlen_req i_req,
    output logic [4:0]         o_len
);
    import cdc_pkg::*;

    logic [YEAR_BITS-1:0] w_prod;
    logic                 w_div25;
    logic                 w_leap;

    // Divisibility by 25 through the modular inverse; by 4 and 16 from low bits.
    assign w_prod  = i_req.year * INV25;
    assign w_div25 = (w_prod <= DIV25_LIM);
    assign w_leap  = (i_req.year[1:0] == 2'd0) && (!w_div25 || (i_req.year[3:0] == 4'd0));

    always_comb begin
        case (i_req.month)
            MONTH_FEB: o_len = w_leap ? DAYS_29 : DAYS_28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: o_len = DAYS_30;
            default: o_len = DAYS_31;
        endcase
    end

endmodule

// ===== design/calendar_date_counter.sv =====
// Top level of the calendar date counter: request capture, sequencer, date registers.
// Depends on cdc_pkg and cdc_mlen.
//
//  channel   | direction | handshake            | payload
//  ----------+-----------+----------------------+---------------------------------------
//  request   | in        | start high, busy low | i_cmd, i_in_year, i_in_month, i_in_day,
//            |           |                      | i_day_count
//  result    | out       | o_done, one cycle    | o_out_year, o_out_month, o_out_day,
//            |           |                      | o_status, o_is_before/same/after
//
// Load and compare pass through their own state before the result strobe. Add and
// subtract walk until day_count days are done or a range limit stops the walk: the
// date moves one day per cycle through the single month-length unit.
// Reset is synchronous and active low; it restores 2000-01-01 and goes idle.
// The result strobe cannot be stalled; a new request may be accepted in the
// strobe cycle itself.
module calendar_date_counter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_cmd,
    input  logic signed [16:0] i_in_year,
    input  logic [3:0]  i_in_month,
    input  logic [4:0]  i_in_day,
    input  logic [15:0] i_day_count,
    output logic        o_done,
    output logic [15:0] o_out_year,
    output logic [3:0]  o_out_month,
    output logic [4:0]  o_out_day,
    output logic [2:0]  o_status,
    output logic        o_is_before,
    output logic        o_is_same,
    output logic        o_is_after
);
    import cdc_pkg::*;

    // Sequencer state and stored date.
    t_state               r_state,  n_state;
    logic [YEAR_BITS-1:0] r_year,   n_year;
    logic [3:0]           r_month,  n_month;
    logic [4:0]           r_day,    n_day;
    logic [15:0]          r_cnt,    n_cnt;

    // Captured request payload.
    logic signed [16:0]   r_in_year;
    logic [3:0]           r_in_month;
    logic [4:0]           r_in_day;

    // Result registers.
    logic                 r_done,   n_done;
    logic [2:0]           r_status, n_status;
    logic                 r_before, n_before;
    logic                 r_same,   n_same;
    logic                 r_after,  n_after;

    logic                    w_accept;
    logic signed [CMP_W-1:0] w_cmp_cur;
    logic signed [CMP_W-1:0] w_cmp_in;
    logic                    w_year_bad;
    t_mlen_req               w_req;
    logic [4:0]              w_len;

    assign busy     = (r_state != ST_IDLE) || !i_rst_n;
    assign w_accept = start && !busy;

    // Widen both years so that a negative input year orders below every stored one.
    assign w_cmp_cur  = CMP_W'(r_year);
    assign w_cmp_in   = CMP_W'(r_in_year);
    assign w_year_bad = r_in_year[16] || (w_cmp_in > CMP_YEAR_MAX);

    // Feed the shared unit: the request date on load, the month before the
    // current one when stepping back, the current date otherwise.
    always_comb begin
        w_req.year  = r_year;
        w_req.month = r_month;
        case (r_state)
            ST_LOAD: begin
                w_req.year  = w_cmp_in[YEAR_BITS-1:0];
                w_req.month = r_in_month;
            end
            ST_BACK: begin
                w_req.month = r_month - 4'd1;
            end
            default: begin
                w_req.month = r_month;
            end
        endcase
    end

    cdc_mlen u_mlen (
        .i_req (w_req),
        .o_len (w_len)
    );

    always_comb begin
        n_state  = r_state;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_status = r_status;
        n_before = r_before;
        n_same   = r_same;
        n_after  = r_after;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_cnt = i_day_count;
                    case (i_cmd)
                        CMD_LOAD: n_state = ST_LOAD;
                        CMD_ADD:  n_state = ST_FWD;
                        CMD_SUB:  n_state = ST_BACK;
                        CMD_CMP:  n_state = ST_CMP;
                        default:  n_state = ST_CMP;
                    endcase
                end
            end

            ST_LOAD: begin
                // Check month, then year, then day; keep the old date on any error.
                n_state  = ST_IDLE;
                n_done   = 1'b1;
                n_before = 1'b0;
                n_same   = 1'b0;
                n_after  = 1'b0;
                n_status = STAT_OK;
                if ((r_in_month < MONTH_JAN) || (r_in_month > MONTH_DEC)) begin
                    n_status = STAT_BAD_MONTH;
                end else if (w_year_bad) begin
                    n_status = STAT_BAD_YEAR;
                end else if ((r_in_day < DAY_FIRST) || (r_in_day > w_len)) begin
                    n_status = STAT_BAD_DAY;
                end else begin
                    n_year  = w_cmp_in[YEAR_BITS-1:0];
                    n_month = r_in_month;
                    n_day   = r_in_day;
                end
            end

            ST_FWD: begin
                n_before = 1'b0;
                n_same   = 1'b0;
                n_after  = 1'b0;
                if (r_cnt == 16'd0) begin
                    n_state  = ST_IDLE;
                    n_done   = 1'b1;
                    n_status = STAT_OK;
                end else if (r_day < w_len) begin
                    n_day = r_day + 5'd1;
                    n_cnt = r_cnt - 16'd1;
                end else if (r_month < MONTH_DEC) begin
                    n_month = r_month + 4'd1;
                    n_day   = DAY_FIRST;
                    n_cnt   = r_cnt - 16'd1;
                end else if (r_year == YEAR_MAX) begin
                    // Stop at the last day of the top year.
                    n_state  = ST_IDLE;
                    n_done   = 1'b1;
                    n_status = STAT_LIMIT;
                end else begin
                    n_year  = r_year + YEAR_BITS'(1);
                    n_month = MONTH_JAN;
                    n_day   = DAY_FIRST;
                    n_cnt   = r_cnt - 16'd1;
                end
            end

            ST_BACK: begin
                n_before = 1'b0;
                n_same   = 1'b0;
                n_after  = 1'b0;
                if (r_cnt == 16'd0) begin
                    n_state  = ST_IDLE;
                    n_done   = 1'b1;
                    n_status = STAT_OK;
                end else if (r_day > DAY_FIRST) begin
                    n_day = r_day - 5'd1;
                    n_cnt = r_cnt - 16'd1;
                end else if (r_month > MONTH_JAN) begin
                    n_month = r_month - 4'd1;
                    n_day   = w_len;
                    n_cnt   = r_cnt - 16'd1;
                end else if (r_year == YEAR_BITS'(0)) begin
                    // Stop at January 1 of year zero.
                    n_state  = ST_IDLE;
                    n_done   = 1'b1;
                    n_status = STAT_LIMIT;
                end else begin
                    n_year  = r_year - YEAR_BITS'(1);
                    n_month = MONTH_DEC;
                    n_day   = DAYS_31;
                    n_cnt   = r_cnt - 16'd1;
                end
            end

            ST_CMP: begin
                // Order by year, then month, then day; the input goes unchecked.
                n_state  = ST_IDLE;
                n_done   = 1'b1;
                n_status = STAT_OK;
                n_same   = 1'b0;
                if (w_cmp_cur != w_cmp_in) begin
                    n_before = (w_cmp_cur < w_cmp_in);
                end else if (r_month != r_in_month) begin
                    n_before = (r_month < r_in_month);
                end else if (r_day != r_in_day) begin
                    n_before = (r_day < r_in_day);
                end else begin
                    n_before = 1'b0;
                    n_same   = 1'b1;
                end
                n_after = !n_before && !n_same;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_year   <= YEAR_BITS'(2000);
            r_month  <= MONTH_JAN;
            r_day    <= DAY_FIRST;
            r_done   <= 1'b0;
            r_status <= STAT_OK;
            r_before <= 1'b0;
            r_same   <= 1'b0;
            r_after  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_done   <= n_done;
            r_status <= n_status;
            r_before <= n_before;
            r_same   <= n_same;
            r_after  <= n_after;
        end
    end

    // Payload capture; no reset needed.
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        if (w_accept) begin
            r_in_year  <= i_in_year;
            r_in_month <= i_in_month;
            r_in_day   <= i_in_day;
        end
    end

    assign o_done      = r_done;
    assign o_out_year  = 16'(r_year);
    assign o_out_month = r_month;
    assign o_out_day   = r_day;
    assign o_status    = r_status;
    assign o_is_before = r_before;
    assign o_is_same   = r_same;
    assign o_is_after  = r_after;

endmodule

// ===== design/cdc_chk.sv =====
// Port-level checker for the calendar date counter, bound to the top level.
// Depends on cdc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cdc_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [15:0] o_out_year,
    input logic [3:0]  o_out_month,
    input logic [4:0]  o_out_day,
    input logic [2:0]  o_status,
    input logic        o_is_before,
    input logic        o_is_same,
    input logic        o_is_after
);
    import cdc_pkg::*;

    // A result only shows once the sequencer is back to idle.
    `CDC_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, o_done |-> !busy, "result strobe while busy")

    // An accepted request keeps the block busy in the following cycle.
    `CDC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "accept without busy")

    // At most one ordering flag, and only with an ok status.
    `CDC_ASSERT_NOW(a_flags, i_clk, i_rst_n, o_done |-> ($onehot0({o_is_before, o_is_same, o_is_after}) && (!(o_is_before || o_is_same || o_is_after) || (o_status == STAT_OK))), "bad compare flags")

    // The stored date holds while no request is in flight.
    `CDC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, (!busy && !o_done) |=> ($stable(o_out_year) && $stable(o_out_month) && $stable(o_out_day)), "date moved while idle")

    // At each result strobe the stored month is 1 to 12 and the day 1 to 31.
    `CDC_ASSERT_NOW(a_range, i_clk, i_rst_n, o_done |-> ((o_out_month >= MONTH_JAN) && (o_out_month <= MONTH_DEC) && (o_out_day >= DAY_FIRST) && (o_out_day <= DAYS_31)), "date out of range")

endmodule

bind calendar_date_counter cdc_chk u_cdc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_out_year  (o_out_year),
    .o_out_month (o_out_month),
    .o_out_day   (o_out_day),
    .o_status    (o_status),
    .o_is_before (o_is_before),
    .o_is_same   (o_is_same),
    .o_is_after  (o_is_after)
);
